FILE: src/cbva_pkg.sv
// ----------------------------------------------------------------------------
// cbva_pkg: shared types and constants of the conv2d layer
// Codes, job and store-write records, and the activation table builder.
// ----------------------------------------------------------------------------
package cbva_pkg;

	localparam int KSIZE_DEF        = 3;
	localparam int MAX_CHANNELS_DEF = 4;
	localparam int MAX_FILTERS_DEF  = 8;
	localparam int MAX_WIDTH_DEF    = 256;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 9;

	// widest fields over the parameter ranges
	localparam int JOB_COL_W  = 12;
	localparam int JOB_SLOT_W = 3;
	localparam int JOB_NCH_W  = 5;
	localparam int JOB_NF_W   = 4;
	localparam int SADDR_W    = 19;
	localparam int BSEL_W     = 6;

	localparam logic [31:0] EXP_STEP = 32'd4228380000;

	typedef enum logic [2:0] {
		REG_IMAGE_WIDTH  = 3'd0,
		REG_IMAGE_HEIGHT = 3'd1,
		REG_CHANNELS     = 3'd2,
		REG_FILTERS      = 3'd3,
		REG_ACTIVATION   = 3'd4
	} cfg_reg_t;

	typedef enum logic [1:0] {
		REQ_WEIGHT = 2'd0,
		REQ_BIAS   = 2'd1,
		REQ_SAMPLE = 2'd2
	} req_t;

	typedef enum logic [1:0] {
		ACT_RELU    = 2'd0,
		ACT_SIGMOID = 2'd1,
		ACT_TANH    = 2'd2
	} act_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MAC,
		ST_DRAIN,
		ST_ROUND,
		ST_ACT,
		ST_OUT
	} back_state_t;

	typedef struct packed {
		logic [8:0] image_width;
		logic [8:0] image_height;
		logic [2:0] channels_in_use;
		logic [3:0] filters_in_use;
		logic [1:0] activation_mode;
	} cfg_t;

	typedef struct packed {
		logic [7:0]            row;
		logic [JOB_COL_W-1:0]  col;
		logic [JOB_SLOT_W-1:0] slot;
		logic [JOB_NCH_W-1:0]  nch;
		logic [JOB_NF_W-1:0]   nf;
		logic [1:0]            mode;
	} job_t;

	typedef struct packed {
		logic                sample_en;
		logic                weight_en;
		logic                bias_en;
		logic [SADDR_W-1:0]  addr;
		logic [BSEL_W-1:0]   bsel;
		logic signed [15:0]  data;
	} store_wr_t;

	typedef logic [2047:0][15:0] act_rom_t;

	// shift-subtract quotient, at most 13 bits
	function automatic logic [63:0] div_q13(logic [63:0] num, logic [63:0] den);
		logic [63:0] rem;
		logic [63:0] q;
		rem = num;
		q = '0;
		for (int b = 12; b >= 0; b--) begin
			if (rem >= (den << b)) begin
				rem = rem - (den << b);
				q = q | (64'd1 << b);
			end
		end
		return q;
	endfunction

	// sigmoid in the lower half, tanh in the upper half
	function automatic act_rom_t build_act_rom();
		act_rom_t     rom;
		logic [63:0]  e_tab [0:1024];
		logic [63:0]  e;
		logic [63:0]  den;
		logic [63:0]  q;
		int           k;
		int           a;
		e_tab[0] = 64'h1_0000_0000;
		for (int i = 1; i <= 1024; i++) begin
			e_tab[i] = 64'(((128'(e_tab[i-1]) * 128'(EXP_STEP)) + (128'(1) << 31)) >> 32);
		end
		for (int i = 0; i < 1024; i++) begin
			k = i - 512;
			a = (k < 0) ? -k : k;
			e = e_tab[a];
			den = (64'd1 << 32) + e;
			q = div_q13(e * 64'd4096 + (den >> 1), den);
			rom[i] = (k <= 0) ? 16'(q) : 16'(64'd4096 - q);
			e = e_tab[2 * a];
			den = (64'd1 << 32) + e;
			q = div_q13(((64'd1 << 32) - e) * 64'd4096 + (den >> 1), den);
			rom[1024 + i] = (k < 0) ? 16'(-q) : 16'(q);
		end
		return rom;
	endfunction

endpackage

FILE: src/cbva_req_if.sv
// ----------------------------------------------------------------------------
// cbva_req_if: input item channel
// Valid/ready channel carrying loads and image samples.
// ----------------------------------------------------------------------------
interface cbva_req_if;
	logic               valid;
	logic               ready;
	logic [1:0]         req_type;
	logic [2:0]         filter_sel;
	logic [1:0]         channel_sel;
	logic [1:0]         tap_row;
	logic [1:0]         tap_col;
	logic signed [15:0] data_value;

	modport source(output valid, req_type, filter_sel, channel_sel, tap_row, tap_col,
		data_value, input ready);
	modport sink(input valid, req_type, filter_sel, channel_sel, tap_row, tap_col,
		data_value, output ready);
endinterface

FILE: src/cbva_res_if.sv
// ----------------------------------------------------------------------------
// cbva_res_if: result item channel
// Valid/ready channel carrying activated filter outputs.
// ----------------------------------------------------------------------------
interface cbva_res_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] result_value;
	logic [2:0]         result_filter;
	logic [7:0]         result_row;
	logic [7:0]         result_col;
	logic               last_of_run;

	modport source(output valid, result_value, result_filter, result_row, result_col,
		last_of_run, input ready);
	modport sink(input valid, result_value, result_filter, result_row, result_col,
		last_of_run, output ready);
endinterface

FILE: src/cbva_queue.sv
// ----------------------------------------------------------------------------
// cbva_queue: two-entry job queue
// Holds window jobs between the front and the back.
// ----------------------------------------------------------------------------
module cbva_queue import cbva_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t din,
	input  logic pop,
	output job_t dout,
	output logic empty,
	output logic full
);

	job_t       mem_q [2];
	logic       wp_q;
	logic       rp_q;
	logic [1:0] cnt_q;

	assign empty = (cnt_q == 2'd0);
	assign full  = (cnt_q == 2'd2);
	assign dout  = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push && !full) begin
			mem_q[wp_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push && !full) begin
				wp_q <= ~wp_q;
			end
			if (pop && !empty) begin
				rp_q <= ~rp_q;
			end
			case ({push && !full, pop && !empty})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

FILE: src/cbva_front.sv
// ----------------------------------------------------------------------------
// cbva_front: item intake
// Decodes items, writes the stores, tracks position, queues window jobs.
// ----------------------------------------------------------------------------
module cbva_front import cbva_pkg::*; #(
	parameter int KSIZE        = KSIZE_DEF,
	parameter int MAX_CHANNELS = MAX_CHANNELS_DEF,
	parameter int MAX_FILTERS  = MAX_FILTERS_DEF,
	parameter int MAX_WIDTH    = MAX_WIDTH_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	cbva_req_if.sink       in_ch,
	input  cfg_t           cfg,
	input  logic           back_idle,
	input  logic           q_empty,
	output logic           q_push,
	output job_t           job,
	output store_wr_t      wr
);

	localparam int CW  = $clog2(MAX_WIDTH);
	localparam int CW1 = CW + 1;
	localparam int CCW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
	localparam int SW  = (KSIZE > 1) ? $clog2(KSIZE) : 1;

	logic [7:0]           row_q;
	logic [CW-1:0]        col_q;
	logic [CCW-1:0]       chan_q;
	logic [SW-1:0]        slot_q;
	logic [CW1-1:0]       width_c;
	logic [8:0]           height_c;
	logic [JOB_NCH_W-1:0] nch_c;
	logic [JOB_NF_W-1:0]  nf_c;
	logic                 accept;
	logic                 is_sample;
	logic                 chan_last;
	logic                 window;
	logic                 weight_ok;
	logic [SADDR_W-1:0]   saddr;
	logic [SADDR_W-1:0]   waddr;

	// clamped configuration
	always_comb begin
		if (32'(cfg.image_width) < KSIZE) begin
			width_c = CW1'(KSIZE);
		end else if (32'(cfg.image_width) > MAX_WIDTH) begin
			width_c = CW1'(MAX_WIDTH);
		end else begin
			width_c = CW1'(cfg.image_width);
		end
		if (32'(cfg.image_height) < KSIZE) begin
			height_c = 9'(KSIZE);
		end else if (cfg.image_height > 9'd256) begin
			height_c = 9'd256;
		end else begin
			height_c = cfg.image_height;
		end
		if (cfg.channels_in_use == 3'd0) begin
			nch_c = JOB_NCH_W'(1);
		end else if (32'(cfg.channels_in_use) > MAX_CHANNELS) begin
			nch_c = JOB_NCH_W'(MAX_CHANNELS);
		end else begin
			nch_c = JOB_NCH_W'(cfg.channels_in_use);
		end
		if (cfg.filters_in_use == 4'd0) begin
			nf_c = JOB_NF_W'(1);
		end else if (32'(cfg.filters_in_use) > MAX_FILTERS) begin
			nf_c = (MAX_FILTERS > 8) ? JOB_NF_W'(8) : JOB_NF_W'(MAX_FILTERS);
		end else if (cfg.filters_in_use > 4'd8) begin
			nf_c = JOB_NF_W'(8);
		end else begin
			nf_c = cfg.filters_in_use;
		end
	end

	// stores are only touched while no window work is pending
	assign in_ch.ready = back_idle && q_empty;
	assign accept      = in_ch.valid && in_ch.ready;
	assign is_sample   = (in_ch.req_type == REQ_SAMPLE);
	assign chan_last   = (32'(chan_q) + 1 >= 32'(nch_c));
	assign window      = (32'(row_q) + 1 >= KSIZE) && (32'(col_q) + 1 >= KSIZE);
	assign weight_ok   = (32'(in_ch.filter_sel) < MAX_FILTERS)
		&& (32'(in_ch.channel_sel) < MAX_CHANNELS)
		&& (32'(in_ch.tap_row) < KSIZE) && (32'(in_ch.tap_col) < KSIZE);

	assign saddr = SADDR_W'((32'(slot_q) * MAX_WIDTH + 32'(col_q)) * MAX_CHANNELS
		+ 32'(chan_q));
	assign waddr = SADDR_W'(((32'(in_ch.filter_sel) * MAX_CHANNELS + 32'(in_ch.channel_sel))
		* KSIZE + 32'(in_ch.tap_row)) * KSIZE + 32'(in_ch.tap_col));

	always_comb begin
		wr.sample_en = accept && is_sample;
		wr.weight_en = accept && (in_ch.req_type == REQ_WEIGHT) && weight_ok;
		wr.bias_en   = accept && (in_ch.req_type == REQ_BIAS)
			&& (32'(in_ch.filter_sel) < MAX_FILTERS);
		wr.addr      = is_sample ? saddr : waddr;
		wr.bsel      = BSEL_W'(in_ch.filter_sel);
		wr.data      = in_ch.data_value;
	end

	assign q_push   = accept && is_sample && chan_last && window;
	assign job.row  = 8'(32'(row_q) + 1 - KSIZE);
	assign job.col  = JOB_COL_W'(32'(col_q) + 1 - KSIZE);
	assign job.slot = JOB_SLOT_W'(slot_q);
	assign job.nch  = nch_c;
	assign job.nf   = nf_c;
	assign job.mode = cfg.activation_mode;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q  <= '0;
			col_q  <= '0;
			chan_q <= '0;
			slot_q <= '0;
		end else if (accept && is_sample) begin
			if (!chan_last) begin
				chan_q <= chan_q + CCW'(1);
			end else begin
				chan_q <= '0;
				if (32'(col_q) + 1 >= 32'(width_c)) begin
					col_q <= '0;
					if (32'(row_q) + 1 >= 32'(height_c)) begin
						row_q  <= '0;
						slot_q <= '0;
					end else begin
						row_q  <= row_q + 8'd1;
						slot_q <= (32'(slot_q) == KSIZE - 1) ? '0 : slot_q + SW'(1);
					end
				end else begin
					col_q <= col_q + CW'(1);
				end
			end
		end
	end

endmodule

FILE: src/cbva_back.sv
// ----------------------------------------------------------------------------
// cbva_back: window engine
// Holds the stores, runs one multiply-accumulate per tap, adds bias,
// rounds, saturates, activates and registers each filter result.
// ----------------------------------------------------------------------------
module cbva_back import cbva_pkg::*; #(
	parameter int KSIZE        = KSIZE_DEF,
	parameter int MAX_CHANNELS = MAX_CHANNELS_DEF,
	parameter int MAX_FILTERS  = MAX_FILTERS_DEF,
	parameter int MAX_WIDTH    = MAX_WIDTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  store_wr_t wr,
	input  logic      q_empty,
	input  job_t      job,
	output logic      q_pop,
	output logic      idle,
	cbva_res_if.source out_ch
);

	localparam int SDEPTH = KSIZE * MAX_WIDTH * MAX_CHANNELS;
	localparam int SAW    = $clog2(SDEPTH);
	localparam int WDEPTH = MAX_FILTERS * MAX_CHANNELS * KSIZE * KSIZE;
	localparam int WAW    = (WDEPTH > 1) ? $clog2(WDEPTH) : 1;
	localparam int FW     = (MAX_FILTERS > 1) ? $clog2(MAX_FILTERS) : 1;
	localparam int CCW    = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
	localparam int KW     = (KSIZE > 1) ? $clog2(KSIZE) : 1;
	localparam int AW     = 34 + $clog2(MAX_CHANNELS * KSIZE * KSIZE);
	localparam act_rom_t ACT_ROM = build_act_rom();

	logic signed [15:0] samp_mem [SDEPTH];
	logic signed [15:0] wt_mem [WDEPTH];
	logic signed [15:0] bias_q [MAX_FILTERS];

	back_state_t        state_q;
	back_state_t        state_d;
	job_t               job_q;
	logic [3:0]         f_q;
	logic [CCW-1:0]     c_q;
	logic [KW-1:0]      ky_q;
	logic [KW-1:0]      kx_q;
	logic               issue;
	logic               tap_last;
	logic               filter_last;
	logic               load_out;
	logic               next_filter;
	logic [SAW-1:0]     saddr;
	logic [WAW-1:0]     waddr;
	logic signed [15:0] samp_s1;
	logic signed [15:0] wt_s1;
	logic               v_s1;
	logic signed [31:0] prod_s2;
	logic               v_s2;
	logic signed [AW-1:0] acc_q;
	logic signed [AW-1:0] sum_c;
	logic signed [AW-1:0] rnd_c;
	logic signed [15:0] v_q;
	logic [15:0]        rom_q;
	logic               out_valid_q;
	logic signed [15:0] out_value_q;
	logic [2:0]         out_filter_q;
	logic [7:0]         out_row_q;
	logic [7:0]         out_col_q;
	logic               out_last_q;
	logic signed [15:0] bias_c;

	// window address of the current tap
	always_comb begin
		int wrow;
		wrow = 32'(job_q.slot) + 1 + 32'(ky_q);
		if (wrow >= KSIZE) begin
			wrow = wrow - KSIZE;
		end
		saddr = SAW'((wrow * MAX_WIDTH + 32'(job_q.col) + 32'(kx_q)) * MAX_CHANNELS
			+ 32'(c_q));
		waddr = WAW'(((32'(f_q) * MAX_CHANNELS + 32'(c_q)) * KSIZE + 32'(ky_q))
			* KSIZE + 32'(kx_q));
	end

	always_ff @(posedge clk) begin
		if (wr.sample_en) begin
			samp_mem[wr.addr[SAW-1:0]] <= wr.data;
		end
		samp_s1 <= samp_mem[saddr];
	end

	always_ff @(posedge clk) begin
		if (wr.weight_en) begin
			wt_mem[wr.addr[WAW-1:0]] <= wr.data;
		end
		wt_s1 <= wt_mem[waddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_FILTERS; i++) begin
				bias_q[i] <= '0;
			end
		end else if (wr.bias_en) begin
			bias_q[wr.bsel[FW-1:0]] <= wr.data;
		end
	end

	assign tap_last    = (32'(kx_q) == KSIZE - 1) && (32'(ky_q) == KSIZE - 1)
		&& (32'(c_q) + 1 >= 32'(job_q.nch));
	assign filter_last = (32'(f_q) + 1 >= 32'(job_q.nf));
	assign idle        = (state_q == ST_IDLE);

	always_comb begin
		state_d     = state_q;
		issue       = 1'b0;
		q_pop       = 1'b0;
		load_out    = 1'b0;
		next_filter = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (!q_empty) begin
					q_pop   = 1'b1;
					state_d = ST_MAC;
				end
			end
			ST_MAC: begin
				issue = 1'b1;
				if (tap_last) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (!v_s1 && !v_s2) begin
					state_d = ST_ROUND;
				end
			end
			ST_ROUND: state_d = ST_ACT;
			ST_ACT:   state_d = ST_OUT;
			ST_OUT: begin
				if (!out_valid_q || out_ch.ready) begin
					load_out = 1'b1;
					if (filter_last) begin
						state_d = ST_IDLE;
					end else begin
						next_filter = 1'b1;
						state_d     = ST_MAC;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			f_q  <= '0;
			c_q  <= '0;
			ky_q <= '0;
			kx_q <= '0;
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= issue;
			v_s2 <= v_s1;
			if (q_pop) begin
				f_q  <= '0;
				c_q  <= '0;
				ky_q <= '0;
				kx_q <= '0;
			end else if (next_filter) begin
				f_q  <= f_q + 4'd1;
				c_q  <= '0;
				ky_q <= '0;
				kx_q <= '0;
			end else if (issue) begin
				if (32'(kx_q) == KSIZE - 1) begin
					kx_q <= '0;
					if (32'(ky_q) == KSIZE - 1) begin
						ky_q <= '0;
						c_q  <= c_q + CCW'(1);
					end else begin
						ky_q <= ky_q + KW'(1);
					end
				end else begin
					kx_q <= kx_q + KW'(1);
				end
			end
		end
	end

	assign bias_c = bias_q[FW'(f_q)];
	assign sum_c  = acc_q + ({{(AW-16){bias_c[15]}}, bias_c} <<< 12);
	assign rnd_c  = (sum_c + AW'(2048)) >>> 12;

	always_ff @(posedge clk) begin
		if (q_pop) begin
			job_q <= job;
		end
		prod_s2 <= samp_s1 * wt_s1;
		if (q_pop || next_filter) begin
			acc_q <= '0;
		end else if (v_s2) begin
			acc_q <= acc_q + {{(AW-32){prod_s2[31]}}, prod_s2};
		end
		if (state_q == ST_ROUND) begin
			if (rnd_c > AW'(32767)) begin
				v_q <= 16'sh7fff;
			end else if (rnd_c < AW'(-32768)) begin
				v_q <= 16'sh8000;
			end else begin
				v_q <= 16'(rnd_c);
			end
		end
		if (state_q == ST_ACT) begin
			rom_q <= ACT_ROM[{job_q.mode == ACT_TANH, ~v_q[15], v_q[14:6]}];
		end
		if (load_out) begin
			if (job_q.mode == ACT_RELU) begin
				out_value_q <= v_q[15] ? 16'sd0 : v_q;
			end else begin
				out_value_q <= rom_q;
			end
			out_filter_q <= f_q[2:0];
			out_row_q    <= job_q.row;
			out_col_q    <= job_q.col[7:0];
			out_last_q   <= filter_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_ch.valid         = out_valid_q;
	assign out_ch.result_value  = out_value_q;
	assign out_ch.result_filter = out_filter_q;
	assign out_ch.result_row    = out_row_q;
	assign out_ch.result_col    = out_col_q;
	assign out_ch.last_of_run   = out_last_q;

endmodule

FILE: src/conv2d_valid_bias_activation.sv
// ----------------------------------------------------------------------------
// conv2d_valid_bias_activation: multichannel valid 2D convolution layer
// Weight, bias and sample items in; one activated result per filter out.
// ----------------------------------------------------------------------------
// Load weights and biases first, then stream samples in raster order with the
// channels of a pixel interleaved. Loads and samples are taken one a cycle
// while no window is in work. When the last channel of a pixel completes a
// KSIZE x KSIZE window, the window engine computes each filter in turn with a
// single multiplier, and the input stalls meanwhile. Results are Q4.12,
// rounded and saturated, then ReLU, sigmoid or tanh (1024-entry tables over
// [-8, 8)). No clearing pass is needed after reset.
module conv2d_valid_bias_activation import cbva_pkg::*; #(
	parameter int KSIZE        = KSIZE_DEF,
	parameter int MAX_CHANNELS = MAX_CHANNELS_DEF,
	parameter int MAX_FILTERS  = MAX_FILTERS_DEF,
	parameter int MAX_WIDTH    = MAX_WIDTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	cbva_req_if.sink              in_ch,
	cbva_res_if.source            out_ch,
	input  logic                  cfg_write_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	cfg_t      cfg_q;
	job_t      push_job;
	job_t      pop_job;
	store_wr_t wr;
	logic      q_push;
	logic      q_pop;
	logic      q_empty;
	logic      q_full;
	logic      back_idle;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.image_width     <= 9'd256;
			cfg_q.image_height    <= 9'd256;
			cfg_q.channels_in_use <= 3'd1;
			cfg_q.filters_in_use  <= 4'd1;
			cfg_q.activation_mode <= ACT_SIGMOID;
		end else if (cfg_write_en) begin
			case (cfg_index)
				REG_IMAGE_WIDTH:  cfg_q.image_width     <= cfg_data;
				REG_IMAGE_HEIGHT: cfg_q.image_height    <= cfg_data;
				REG_CHANNELS:     cfg_q.channels_in_use <= cfg_data[2:0];
				REG_FILTERS:      cfg_q.filters_in_use  <= cfg_data[3:0];
				REG_ACTIVATION:   cfg_q.activation_mode <= cfg_data[1:0];
				default:          cfg_q <= cfg_q;
			endcase
		end
	end

	cbva_front #(
		.KSIZE(KSIZE), .MAX_CHANNELS(MAX_CHANNELS),
		.MAX_FILTERS(MAX_FILTERS), .MAX_WIDTH(MAX_WIDTH)
	) u_front (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .cfg(cfg_q),
		.back_idle(back_idle), .q_empty(q_empty), .q_push(q_push),
		.job(push_job), .wr(wr)
	);

	cbva_queue u_queue (
		.clk(clk), .arst_n(arst_n), .push(q_push), .din(push_job),
		.pop(q_pop), .dout(pop_job), .empty(q_empty), .full(q_full)
	);

	cbva_back #(
		.KSIZE(KSIZE), .MAX_CHANNELS(MAX_CHANNELS),
		.MAX_FILTERS(MAX_FILTERS), .MAX_WIDTH(MAX_WIDTH)
	) u_back (
		.clk(clk), .arst_n(arst_n), .wr(wr), .q_empty(q_empty), .job(pop_job),
		.q_pop(q_pop), .idle(back_idle), .out_ch(out_ch)
	);

	// stores never change under a window in work
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_ch.valid && in_ch.ready) |-> (back_idle && q_empty))
		else $error("item accepted while window work pending");

	assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_full)
		else $error("job queue overflow");

	assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |=> !back_idle)
		else $error("job popped but engine stayed idle");

endmodule

FILE: sim/tb_conv2d_valid_bias_activation.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_conv2d_valid_bias_activation: self-checking bench of the conv2d layer
// Loads weights and biases, streams whole images under several settings and
// checks every result against an in-bench model of the layer.
// ----------------------------------------------------------------------------
module tb_conv2d_valid_bias_activation;
	import cbva_pkg::*;

	localparam logic [1:0] REQ_NONE = 2'd3;
	localparam logic [1:0] ACT_ALT  = 2'd3;
	localparam int KS = 3;

	typedef struct {
		logic signed [15:0] value;
		logic [2:0]         filter;
		logic [7:0]         row;
		logic [7:0]         col;
		logic               last;
	} conv_out_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_write_en = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	cbva_req_if req_bus();
	cbva_res_if res_bus();

	conv2d_valid_bias_activation u_dut (
		.clk(clk), .arst_n(arst_n), .in_ch(req_bus.sink), .out_ch(res_bus.source),
		.cfg_write_en(cfg_write_en), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	// layer model state
	int unsigned m_width = 256, m_height = 256, m_nch = 1, m_nf = 1, m_mode = 1;
	int          m_samples [3072];
	int          m_weights [288];
	int          m_bias [8];
	int unsigned m_row, m_col, m_chan;
	int          sig_lut [1024];
	int          tanh_lut [1024];

	conv_out_t   pending_outputs [$];
	int          errors = 0;
	bit          quiet = 1'b0;
	int          samples_sent = 0;

	function automatic void build_luts();
		logic [63:0]  ex [0:1024];
		logic [127:0] p;
		longint unsigned e, den, sn, t;
		int k;
		int a;
		ex[0] = 64'h1_0000_0000;
		for (int i = 1; i <= 1024; i++) begin
			p = 128'(ex[i-1]) * 128'(32'd4228380000) + (128'(1) << 31);
			ex[i] = 64'(p >> 32);
		end
		for (int i = 0; i < 1024; i++) begin
			k = i - 512;
			a = (k < 0) ? -k : k;
			e = ex[a];
			den = (64'd1 << 32) + e;
			sn = (e * 4096 + den / 2) / den;
			sig_lut[i] = (k <= 0) ? int'(sn) : 4096 - int'(sn);
			e = ex[2 * a];
			den = (64'd1 << 32) + e;
			t = (((64'd1 << 32) - e) * 4096 + den / 2) / den;
			tanh_lut[i] = (k < 0) ? -int'(t) : int'(t);
		end
	endfunction

	function automatic int unsigned clip(int unsigned v, int unsigned lo, int unsigned hi);
		return (v < lo) ? lo : ((v > hi) ? hi : v);
	endfunction

	function automatic int filter_response(int unsigned f, int unsigned nch);
		longint acc = 0;
		longint v;
		int unsigned r;
		int unsigned c;
		int idx;
		for (int unsigned ch = 0; ch < nch; ch++)
			for (int unsigned ky = 0; ky < KS; ky++)
				for (int unsigned kx = 0; kx < KS; kx++) begin
					r = (m_row + 1 - KS + ky) % KS;
					c = m_col + 1 - KS + kx;
					acc += longint'(m_samples[((r * 256 + c) * 4 + ch) % 3072]) *
						longint'(m_weights[((f * 4 + ch) * KS + ky) * KS + kx]);
				end
		acc += longint'(m_bias[f]) * 4096;
		v = (acc + 2048) >>> 12;
		if (v > 32767) v = 32767;
		if (v < -32768) v = -32768;
		idx = (int'(v) + 32768) >> 6;
		case (m_mode)
			ACT_RELU: return (v < 0) ? 0 : int'(v);
			ACT_TANH: return tanh_lut[idx];
			default: return sig_lut[idx];
		endcase
	endfunction

	function automatic void model_item(logic [1:0] rt, logic [2:0] fs, logic [1:0] cs,
		logic [1:0] tr, logic [1:0] tc, logic signed [15:0] val);
		int unsigned w, h, nch, nf;
		conv_out_t o;
		case (rt)
			REQ_WEIGHT: if (tr < KS && tc < KS)
				m_weights[((fs * 4 + cs) * KS + tr) * KS + tc] = val;
			REQ_BIAS: m_bias[fs] = val;
			REQ_SAMPLE: begin
				w = clip(m_width, KS, 256);
				h = clip(m_height, KS, 256);
				nch = clip(m_nch, 1, 4);
				nf = clip(m_nf, 1, 8);
				m_samples[(((m_row % KS) * 256 + m_col) * 4 + m_chan) % 3072] = val;
				if (m_chan + 1 < nch) begin
					m_chan++;
					return;
				end
				m_chan = 0;
				if (m_row + 1 >= KS && m_col + 1 >= KS) begin
					for (int unsigned f = 0; f < nf; f++) begin
						o.value = 16'(filter_response(f, nch));
						o.filter = 3'(f);
						o.row = 8'(m_row + 1 - KS);
						o.col = 8'(m_col + 1 - KS);
						o.last = (f + 1 == nf);
						pending_outputs.push_back(o);
					end
				end
				if (m_col + 1 >= w) begin
					m_col = 0;
					m_row = (m_row + 1 >= h) ? 0 : m_row + 1;
				end else begin
					m_col++;
				end
			end
			default: ;
		endcase
	endfunction

	task automatic send_item(logic [1:0] rt, logic [2:0] fs, logic [1:0] cs,
		logic [1:0] tr, logic [1:0] tc, logic signed [15:0] val);
		while (!quiet && $urandom_range(0, 99) < 24) begin
			req_bus.valid <= 1'b0;
			@(posedge clk);
		end
		req_bus.valid <= 1'b1;
		req_bus.req_type <= rt;
		req_bus.filter_sel <= fs;
		req_bus.channel_sel <= cs;
		req_bus.tap_row <= tr;
		req_bus.tap_col <= tc;
		req_bus.data_value <= val;
		do @(posedge clk); while (!req_bus.ready);
		model_item(rt, fs, cs, tr, tc, val);
		if (rt == REQ_SAMPLE) samples_sent++;
	endtask

	task automatic send_sample(logic signed [15:0] val);
		send_item(REQ_SAMPLE, 3'($urandom), 2'($urandom), 2'($urandom), 2'($urandom), val);
	endtask

	function automatic logic signed [15:0] rand_value();
		case ($urandom_range(0, 5))
			0: return 16'($urandom);
			1: return $urandom_range(0, 1) ? 16'sh7fff : -16'sh8000;
			default: return 16'($signed($urandom_range(0, 4095)) - 2048);
		endcase
	endfunction

	task automatic write_reg(cfg_reg_t idx, int unsigned val);
		cfg_write_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= CFG_DATA_W'(val);
		@(posedge clk);
		cfg_write_en <= 1'b0;
		case (idx)
			REG_IMAGE_WIDTH:  m_width = val & 9'h1ff;
			REG_IMAGE_HEIGHT: m_height = val & 9'h1ff;
			REG_CHANNELS:     m_nch = val & 3'h7;
			REG_FILTERS:      m_nf = val & 4'hf;
			default:          m_mode = val & 2'h3;
		endcase
	endtask

	task automatic wait_idle();
		req_bus.valid <= 1'b0;
		while (pending_outputs.size() > 0) @(posedge clk);
		repeat (400) @(posedge clk);
	endtask

	task automatic set_shape(int unsigned w, int unsigned h, int unsigned nch,
		int unsigned nf, int unsigned mode);
		wait_idle();
		write_reg(REG_IMAGE_WIDTH, w);
		write_reg(REG_IMAGE_HEIGHT, h);
		write_reg(REG_CHANNELS, nch);
		write_reg(REG_FILTERS, nf);
		write_reg(REG_ACTIVATION, mode);
	endtask

	// one whole image at the current shape, optional noise between samples
	task automatic send_image(bit noisy);
		int unsigned n;
		n = clip(m_width, KS, 256) * clip(m_height, KS, 256) * clip(m_nch, 1, 4);
		for (int unsigned i = 0; i < n; i++) begin
			if (noisy && $urandom_range(0, 99) < 8) begin
				case ($urandom_range(0, 2))
					0: send_item(REQ_NONE, 3'($urandom), 2'($urandom), 2'($urandom),
						2'($urandom), 16'($urandom));
					1: send_item(REQ_BIAS, 3'($urandom), 2'($urandom), 2'($urandom),
						2'($urandom), rand_value());
					default: send_item(REQ_WEIGHT, 3'($urandom), 2'($urandom),
						2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)), rand_value());
				endcase
			end
			send_sample(rand_value());
		end
	endtask

	task automatic test_loads();
		for (int f = 0; f < 8; f++) begin
			for (int c = 0; c < 4; c++)
				for (int r = 0; r < KS; r++)
					for (int k = 0; k < KS; k++)
						send_item(REQ_WEIGHT, 3'(f), 2'(c), 2'(r), 2'(k),
							16'($signed($urandom_range(0, 1023)) - 512));
			send_item(REQ_BIAS, 3'(f), 2'd0, 2'd0, 2'd0, rand_value());
		end
		// loads outside the kernel, and an item of unknown type, are dropped
		send_item(REQ_WEIGHT, 3'd7, 2'd3, 2'd3, 2'd1, 16'sh7fff);
		send_item(REQ_WEIGHT, 3'd2, 2'd1, 2'd0, 2'd3, -16'sh8000);
		send_item(REQ_NONE, 3'd5, 2'd2, 2'd1, 2'd1, 16'sh1234);
	endtask

	task automatic test_directed();
		logic signed [15:0] pix [9];
		pix = '{16'sh7fff, -16'sh8000, 16'sh0000, 16'sh1000, -16'sh1000,
			16'sh0001, -16'sh0001, 16'sh7fff, -16'sh8000};
		for (int mode = 0; mode <= int'(ACT_ALT); mode++) begin
			set_shape(3, 3, 1, 8, mode);
			foreach (pix[i]) send_sample(pix[i]);
		end
		// out of range settings clamp: width 0 -> 3, height 2 -> 3, channels 7 -> 4, filters 15 -> 8
		set_shape(0, 2, 7, 15, ACT_TANH);
		send_image(1'b0);
		set_shape(4, 3, 0, 0, ACT_RELU);
		send_image(1'b0);
	endtask

	task automatic test_random_images();
		while (samples_sent < 100) begin
			set_shape($urandom_range(3, 4), 3, $urandom_range(1, 2),
				$urandom_range(1, 8), $urandom_range(0, 3));
			send_image(1'b1);
		end
	endtask

	// a stretch with no idling on either side
	task automatic test_no_idle();
		quiet = 1'b1;
		set_shape(3, 3, 2, 8, ACT_SIGMOID);
		send_image(1'b0);
		quiet = 1'b0;
	endtask

	always @(posedge clk) begin
		res_bus.ready <= quiet ? 1'b1 : ($urandom_range(0, 99) >= 24);
	end

	always @(posedge clk) begin
		conv_out_t o;
		if (arst_n && res_bus.valid && res_bus.ready) begin
			if (pending_outputs.size() == 0) begin
				$display("%0t: unexpected result, value %0d filter %0d", $time,
					res_bus.result_value, res_bus.result_filter);
				errors++;
			end else begin
				o = pending_outputs.pop_front();
				if (res_bus.result_value !== o.value) begin
					$display("%0t: value expected %0d actual %0d", $time, o.value,
						res_bus.result_value);
					errors++;
				end
				if (res_bus.result_filter !== o.filter) begin
					$display("%0t: filter expected %0d actual %0d", $time, o.filter,
						res_bus.result_filter);
					errors++;
				end
				if (res_bus.result_row !== o.row) begin
					$display("%0t: row expected %0d actual %0d", $time, o.row,
						res_bus.result_row);
					errors++;
				end
				if (res_bus.result_col !== o.col) begin
					$display("%0t: col expected %0d actual %0d", $time, o.col,
						res_bus.result_col);
					errors++;
				end
				if (res_bus.last_of_run !== o.last) begin
					$display("%0t: last expected %0d actual %0d", $time, o.last,
						res_bus.last_of_run);
					errors++;
				end
			end
		end
	end

	initial begin
		#2_000_000;
		$display("FAILURE");
		$finish;
	end

	initial begin
		req_bus.valid = 1'b0;
		req_bus.req_type = REQ_NONE;
		req_bus.filter_sel = '0;
		req_bus.channel_sel = '0;
		req_bus.tap_row = '0;
		req_bus.tap_col = '0;
		req_bus.data_value = '0;
		build_luts();
		foreach (m_bias[i]) m_bias[i] = 0;
		m_row = 0;
		m_col = 0;
		m_chan = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_loads();
		test_directed();
		test_random_images();
		test_no_idle();
		wait_idle();
		if (errors == 0 && pending_outputs.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule

FILE: files.f
src/cbva_pkg.sv
src/cbva_req_if.sv
src/cbva_res_if.sv
src/cbva_queue.sv
src/cbva_front.sv
src/cbva_back.sv
src/conv2d_valid_bias_activation.sv
sim/tb_conv2d_valid_bias_activation.sv
